FILE: src/measurement_to_motion_state_macros.svh
// assertion helpers for the measurement to motion state block
// the assertions are written against signals named clk and rst
`ifndef MEASUREMENT_TO_MOTION_STATE_MACROS_SVH
`define MEASUREMENT_TO_MOTION_STATE_MACROS_SVH
`ifndef SYNTHESIS
`define M2MS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("m2ms check failed");
`define M2MS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("m2ms reset check failed");
`else
`define M2MS_ASSERT(label, prop)
`define M2MS_ASSERT_RST(label, prop)
`endif
`endif

FILE: src/m2ms_pkg.sv
`default_nettype none
package m2ms_pkg;

  localparam int DATA_W = 32;
  localparam int GUARD_BITS = 16;
  localparam int ANG_EXTRA = 30;
  localparam int MAG_W = DATA_W + GUARD_BITS + 3;
  localparam int PRE_SHIFT = 31 - GUARD_BITS;
  localparam int DEF_CORDIC_ITERATIONS = 16;
  localparam int DEF_FRAC_BITS = 16;
  // power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef enum logic [1:0] {
    KIND_LIDAR = 2'd0,
    KIND_RADAR = 2'd1,
    KIND_STATE = 2'd2,
    KIND_TRUTH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_PASS    = 2'd0,
    OP_ROT_POS = 2'd1,
    OP_ROT_VEL = 2'd2,
    OP_VEC     = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed;
    logic signed [31:0] heading;
    logic signed [31:0] turn_rate;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } res_t;

  typedef struct packed {
    res_t               res;
    logic signed [31:0] mag_a;
    logic signed [31:0] mag_b;
    logic signed [31:0] angle;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  function automatic logic op_rotates(input op_t op);
    return (op == OP_ROT_POS) || (op == OP_ROT_VEL);
  endfunction

  // shift and subtract division, used only for elaboration-time constants
  function automatic logic [63:0] cdiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // pi times 2^(60-s), rounded
  function automatic logic [63:0] pi_scaled(input int s);
    return (PI_Q60 + (64'd1 << (s - 1))) >> s;
  endfunction

  // atan(2^-i) with 60 fraction bits, power series
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    int          k;
    sum = '0;
    k = 0;
    if (i == 0) return PI_Q60 >> 2;
    p = 64'd1 << (60 - i);
    while (p != 0) begin
      term = cdiv64(p, 64'(2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = p >> (2 * i);
      k = k + 1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_step(input int i, input int frac);
    int s;
    s = 30 - frac;
    return (atan_q60(i) + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v_in;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // gain compensation with 31 fraction bits
  function automatic logic [63:0] gain_q31(input int iters);
    logic [63:0] p;
    p = 64'h8000000000000000;
    for (int i = 1; i < iters; i++) p = p + (p >> (2 * i));
    return cdiv64(64'd1 << 62, isqrt64(p));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/m2ms_front.sv
`default_nettype none
module m2ms_front import m2ms_pkg::*; (
  input  wire logic               in_valid,
  input  wire logic [1:0]         action,
  input  wire logic signed [31:0] first_value,
  input  wire logic signed [31:0] second_value,
  input  wire logic signed [31:0] third_value,
  input  wire logic signed [31:0] fourth_value,
  input  wire logic signed [31:0] fifth_value,
  input  wire logic               q_full,
  output logic                    in_stall,
  output logic                    push,
  output job_t                    job
);

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    job = '0;
    job.res.op = OP_PASS;
    job.res.pos_x = first_value;
    job.res.pos_y = second_value;
    case (action)
      KIND_RADAR: begin
        job.res.op = OP_ROT_POS;
        job.mag_a = first_value;
        job.angle = second_value;
      end
      KIND_STATE: begin
        job.res.op = OP_ROT_VEL;
        job.res.speed = third_value;
        job.res.heading = fourth_value;
        job.res.turn_rate = fifth_value;
        job.mag_a = third_value;
        job.angle = fourth_value;
      end
      KIND_TRUTH: begin
        job.res.vel_x = third_value;
        job.res.vel_y = fourth_value;
        job.mag_a = third_value;
        job.mag_b = fourth_value;
        // zero velocity leaves speed and heading at zero
        if (third_value != 32'sd0 || fourth_value != 32'sd0) begin
          job.res.op = OP_VEC;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/m2ms_queue.sv
`default_nettype none
module m2ms_queue import m2ms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      head,
  output q_stat_t   stat
);

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head = entry[rd_ptr];
  assign stat.count = count;
  assign stat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wr_job;
  end

endmodule
`default_nettype wire

FILE: src/m2ms_back.sv
`default_nettype none
module m2ms_back import m2ms_pkg::*; #(
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic q_empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] speed,
  output logic signed [31:0] heading,
  output logic signed [31:0] turn_rate,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int ANG_W = FRAC_BITS + ANG_EXTRA + 4;
  localparam int Z_W = DATA_W + ANG_EXTRA;
  localparam int RED = 29 - FRAC_BITS;
  localparam logic [63:0] TWO_PI_C = pi_scaled(29 - FRAC_BITS);
  localparam logic signed [ANG_W-1:0] TWO_S = ANG_W'(pi_scaled(29 - FRAC_BITS));
  localparam logic signed [ANG_W-1:0] PI_S = ANG_W'(pi_scaled(30 - FRAC_BITS));
  localparam logic signed [ANG_W-1:0] HALF_S = ANG_W'(pi_scaled(31 - FRAC_BITS));
  localparam logic signed [31:0] K_S = 32'(gain_q31(CORDIC_ITERATIONS));
  localparam logic signed [63:0] PRE_HALF = 64'sd1 <<< (PRE_SHIFT - 1);
  localparam logic signed [63:0] G_HALF = 64'sd1 <<< (GUARD_BITS - 1);
  localparam logic signed [63:0] Z_HALF = 64'sd1 <<< (ANG_EXTRA - 1);

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  logic [Z_W-1:0]           red_tab [1:RED];
  logic signed [ANG_W-1:0]  atan_tab [N];

  for (genvar gj = 1; gj <= RED; gj++) begin : g_red
    localparam logic [63:0] STEP = TWO_PI_C << (RED - gj);
    assign red_tab[gj] = Z_W'(STEP);
  end
  for (genvar gi = 0; gi < N; gi++) begin : g_atan
    localparam logic [63:0] ATAN = atan_step(gi, FRAC_BITS);
    assign atan_tab[gi] = ANG_W'(ATAN);
  end

  // entry: gain multiply and magnitude of the angle
  logic signed [63:0] pa;
  logic signed [63:0] pb;
  logic               phi_neg;
  logic [31:0]        phi_abs;
  assign pa = head.mag_a * K_S;
  assign pb = head.mag_b * K_S;
  assign phi_neg = head.angle[31];
  assign phi_abs = phi_neg ? (~head.angle + 32'd1) : head.angle;

  // restoring reduction modulo two pi, one quotient bit per stage
  logic [RED:0]       rv;
  res_t               rres [RED+1];
  logic signed [63:0] rpa [RED+1];
  logic signed [63:0] rpb [RED+1];
  logic [Z_W-1:0]     rz [RED+1];
  logic [RED:0]       rneg;

  // wrap to [-pi, pi] and gain rounding
  logic                    wv;
  res_t                    wres;
  logic signed [MAG_W-1:0] wx;
  logic signed [MAG_W-1:0] wy;
  logic signed [ANG_W-1:0] wz;
  logic signed [ANG_W-1:0] zmag;
  logic signed [ANG_W-1:0] zs;
  logic signed [ANG_W-1:0] zw;
  logic signed [63:0]      pre_xl;
  logic signed [63:0]      pre_yl;

  always_comb begin
    zmag = ANG_W'(rz[RED]);
    zs = rneg[RED] ? -zmag : zmag;
    if (zs > PI_S) zw = zs - TWO_S;
    else if (zs < -PI_S) zw = zs + TWO_S;
    else zw = zs;
    pre_xl = (rpa[RED] + PRE_HALF) >>> PRE_SHIFT;
    pre_yl = (rpb[RED] + PRE_HALF) >>> PRE_SHIFT;
  end

  // half-turn fold for rotation, quadrant swap for vectoring
  logic signed [MAG_W-1:0] fx;
  logic signed [MAG_W-1:0] fy;
  logic signed [ANG_W-1:0] fz;

  always_comb begin
    fx = wx;
    fy = wy;
    fz = '0;
    if (op_rotates(wres.op)) begin
      fy = '0;
      fz = wz;
      if (wz > HALF_S) begin
        fz = wz - PI_S;
        fx = -wx;
      end else if (wz < -HALF_S) begin
        fz = wz + PI_S;
        fx = -wx;
      end
    end else if (wx < 0) begin
      if (wy >= 0) begin
        fx = wy;
        fy = -wx;
        fz = HALF_S;
      end else begin
        fx = -wy;
        fy = wx;
        fz = -HALF_S;
      end
    end
  end

  // one micro-rotation per stage
  logic [N:0]              cv;
  res_t                    cres [N+1];
  logic signed [MAG_W-1:0] cx [N+1];
  logic signed [MAG_W-1:0] cy [N+1];
  logic signed [ANG_W-1:0] cz [N+1];
  logic signed [MAG_W-1:0] nx [N];
  logic signed [MAG_W-1:0] ny [N];
  logic signed [ANG_W-1:0] nz [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (op_rotates(cres[i].op) ? (cz[i] >= 0) : (cy[i] < 0)) begin
        nx[i] = cx[i] - (cy[i] >>> i);
        ny[i] = cy[i] + (cx[i] >>> i);
        nz[i] = cz[i] - atan_tab[i];
      end else begin
        nx[i] = cx[i] + (cy[i] >>> i);
        ny[i] = cy[i] - (cx[i] >>> i);
        nz[i] = cz[i] + atan_tab[i];
      end
    end
  end

  // final rounding, saturation and field select
  logic signed [63:0] xr;
  logic signed [63:0] yr;
  logic signed [63:0] zr;
  res_t               fin;

  always_comb begin
    xr = (64'(cx[N]) + G_HALF) >>> GUARD_BITS;
    yr = (64'(cy[N]) + G_HALF) >>> GUARD_BITS;
    zr = (64'(cz[N]) + Z_HALF) >>> ANG_EXTRA;
    fin = cres[N];
    case (cres[N].op)
      OP_ROT_POS: begin
        fin.pos_x = sat32(xr);
        fin.pos_y = sat32(yr);
      end
      OP_ROT_VEL: begin
        fin.vel_x = sat32(xr);
        fin.vel_y = sat32(yr);
      end
      OP_VEC: begin
        fin.speed = sat32(xr);
        fin.heading = sat32(zr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= '0;
      wv <= 1'b0;
      cv <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      rv <= {rv[RED-1:0], pop};
      wv <= rv[RED];
      cv <= {cv[N-1:0], wv};
      out_valid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rres[0] <= head.res;
      rpa[0] <= pa;
      rpb[0] <= pb;
      rz[0] <= Z_W'({phi_abs, {ANG_EXTRA{1'b0}}});
      rneg[0] <= phi_neg;
      for (int j = 1; j <= RED; j++) begin
        rres[j] <= rres[j-1];
        rpa[j] <= rpa[j-1];
        rpb[j] <= rpb[j-1];
        rneg[j] <= rneg[j-1];
        rz[j] <= (rz[j-1] >= red_tab[j]) ? (rz[j-1] - red_tab[j]) : rz[j-1];
      end
      wres <= rres[RED];
      wx <= pre_xl[MAG_W-1:0];
      wy <= pre_yl[MAG_W-1:0];
      wz <= zw;
      cres[0] <= wres;
      cx[0] <= fx;
      cy[0] <= fy;
      cz[0] <= fz;
      for (int i = 0; i < N; i++) begin
        cres[i+1] <= cres[i];
        cx[i+1] <= nx[i];
        cy[i+1] <= ny[i];
        cz[i+1] <= nz[i];
      end
      pos_x <= fin.pos_x;
      pos_y <= fin.pos_y;
      speed <= fin.speed;
      heading <= fin.heading;
      turn_rate <= fin.turn_rate;
      vel_x <= fin.vel_x;
      vel_y <= fin.vel_y;
    end
  end

endmodule
`default_nettype wire

FILE: src/measurement_to_motion_state.sv
// measurement to motion state converter
// input channel: in_valid / in_stall with action (record kind) and five
// Q15.16 values; an item is taken on a clock edge with in_valid high and
// in_stall low. output channel: out_valid / out_stall with the seven
// motion-state and Cartesian fields, taken the same way.
// classification feeds a four-entry queue; the back end is a pipelined
// angle reduction followed by a CORDIC with one micro-rotation per stage.
// throughput: one item per cycle while the output is not stalled.
// path: the queue entry, then the reduction stages, the wrap register,
// the CORDIC stages and the output register; the reduction stage count
// is set by the quotient width of the modulo two pi step.
// a stalled output freezes the whole back pipeline; the queue keeps taking
// items until its four entries are full, then in_stall rises.
// reset (rst, synchronous) empties the queue and clears every valid bit;
// no result is left pending after reset.
`default_nettype none
`include "measurement_to_motion_state_macros.svh"
module measurement_to_motion_state import m2ms_pkg::*; #(
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic signed [31:0] first_value,
  input  wire logic signed [31:0] second_value,
  input  wire logic signed [31:0] third_value,
  input  wire logic signed [31:0] fourth_value,
  input  wire logic signed [31:0] fifth_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      speed,
  output logic signed [31:0]      heading,
  output logic signed [31:0]      turn_rate,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y
);

  logic    push;
  logic    pop;
  job_t    job;
  job_t    head;
  q_stat_t q_stat;

  m2ms_front u_front (
    .in_valid     (in_valid),
    .action       (action),
    .first_value  (first_value),
    .second_value (second_value),
    .third_value  (third_value),
    .fourth_value (fourth_value),
    .fifth_value  (fifth_value),
    .q_full       (q_stat.full),
    .in_stall     (in_stall),
    .push         (push),
    .job          (job)
  );

  m2ms_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (job),
    .pop    (pop),
    .head   (head),
    .stat   (q_stat)
  );

  m2ms_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .FRAC_BITS         (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .speed     (speed),
    .heading   (heading),
    .turn_rate (turn_rate),
    .vel_x     (vel_x),
    .vel_y     (vel_y)
  );

  `M2MS_ASSERT_RST(a_reset_clears_output, rst |=> !out_valid)
  `M2MS_ASSERT(a_no_pop_while_held, (out_valid && out_stall) |-> !pop)
  `M2MS_ASSERT(a_pop_only_nonempty, pop |-> (q_stat.count != '0))

endmodule
`default_nettype wire
